// ===== sv/pairwise_identity_distance_core_assert.svh =====
// Assertion macros for the pairwise identity distance core.
// Included by files that check their own logic; no other dependencies.
`ifndef PAIRWISE_IDENTITY_DISTANCE_CORE_ASSERT_SVH
`define PAIRWISE_IDENTITY_DISTANCE_CORE_ASSERT_SVH

// Clocked assertion with explicit clock and active-low reset
`define PIDC_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the usual clk_i / rst_ni pair
`define PIDC_ASSERT(lbl, prop, msg) \
  `PIDC_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/pidc_pkg.sv =====
// Shared constants, types and the gap test for the pairwise identity distance core.
// No dependencies; imported by every module of the block.
package pidc_pkg;

  // Limits
  localparam int MAX_COLUMNS = 65536;
  localparam int MAX_PAIRS   = 1048576;

  // Widths
  localparam int RES_W   = 8;
  localparam int FRAC_W  = 16;
  localparam int Q_W     = FRAC_W + 1;                  // Q1.16 result
  localparam int COL_W   = $clog2(MAX_COLUMNS + 1);     // site / match counters
  localparam int PAIR_W  = $clog2(MAX_PAIRS + 1);       // pair counter
  localparam int SUM_W   = Q_W + PAIR_W - 1;            // running sum
  localparam int STEP_W  = $clog2(Q_W + 1);             // divider step counter
  localparam int IN_DW   = 2 * RES_W;
  localparam int OUT_DW  = ((4 * Q_W + 7) / 8) * 8;
  localparam int OUT_UW  = 2;

  localparam int ONE_Q16 = 1 << FRAC_W;

  // Controller to datapath commands
  typedef struct packed {
    logic col_acc;     // column beat accepted
    logic pair_begin;  // pair closed, start result
    logic div_start;   // launch divider
    logic div_avg;     // divider operands: average (else distance)
    logic dist_take;   // capture quotient as distance
    logic avg_take;    // capture quotient as average
    logic stat_upd;    // fold distance into set statistics
    logic out_load;    // move result into output register
  } pidc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sites_zero;
    logic last_pair;
    logic pairs_zero;
    logic div_busy;
    logic div_done;
    logic out_free;
  } pidc_sts_t;

  // ASCII punctuation counts as a gap
  function automatic logic is_gap(input logic [RES_W-1:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

endpackage

// ===== sv/pidc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the pairwise distance core.
// Depends on pidc_pkg; quotient must fit Q_W bits (dividend < divisor * 2^Q_W).
module pidc_div import pidc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [PAIR_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [Q_W-1:0]    quotient_o
);

  logic [PAIR_W-1:0] rem_q, rem_d;
  logic [PAIR_W-1:0] dvs_q;
  logic [Q_W-1:0]    dvd_q;
  logic [Q_W-1:0]    quo_q, quo_d;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [PAIR_W:0]   trial;
  logic [PAIR_W:0]   diff;
  logic              qbit;

  // One shift-and-subtract step
  always_comb begin
    trial = {rem_q, dvd_q[Q_W-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? diff[PAIR_W-1:0] : trial[PAIR_W-1:0];
    quo_d = {quo_q[Q_W-2:0], qbit};
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == STEP_W'(1));
      if (start_i) begin
        cnt_q <= STEP_W'(Q_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - STEP_W'(1);
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= PAIR_W'(dividend_i[SUM_W-1:Q_W]);
      dvd_q <= dividend_i[Q_W-1:0];
      dvs_q <= divisor_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[Q_W-2:0], 1'b0};
      quo_q <= quo_d;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== sv/pidc_dp.sv =====
// Datapath of the pairwise distance core: counters, set statistics, divider, output register.
// Depends on pidc_pkg and pidc_div; driven by pidc_ctrl through pidc_cmd_t.
module pidc_dp import pidc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pidc_cmd_t         cmd_i,
  output pidc_sts_t         sts_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [RES_W-1:0]  residue_a_i,
  input  logic [RES_W-1:0]  residue_b_i,
  input  logic              last_column_i,
  input  logic              last_pair_i,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  output logic [OUT_DW-1:0] m_tdata_o,
  output logic [OUT_UW-1:0] m_tuser_o,
  output logic              m_tlast_o
);

  logic              mode_q;
  logic [COL_W-1:0]  site_q, match_q;
  logic              last_pair_q;
  logic              none_q;
  logic [Q_W-1:0]    dist_q, avg_q;
  logic [Q_W-1:0]    min_q, max_q;
  logic [SUM_W-1:0]  sum_q;
  logic [PAIR_W-1:0] pcnt_q;
  logic              out_valid_q;
  logic [OUT_DW-1:0] out_data_q;
  logic [OUT_UW-1:0] out_user_q;
  logic              out_last_q;

  logic [COL_W-1:0]  num;
  logic [SUM_W-1:0]  div_dvd;
  logic [PAIR_W-1:0] div_dvs;
  logic              div_busy, div_done;
  logic [Q_W-1:0]    div_quo;
  logic              col_site;
  logic              set_empty;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Column counting; counts clear once the pair has been folded in
  assign col_site = !is_gap(residue_a_i) && !is_gap(residue_b_i) &&
                    (site_q < COL_W'(MAX_COLUMNS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_q      <= '0;
      match_q     <= '0;
      last_pair_q <= 1'b0;
    end else if (cmd_i.stat_upd) begin
      site_q  <= '0;
      match_q <= '0;
    end else if (cmd_i.col_acc) begin
      if (col_site) begin
        site_q <= site_q + COL_W'(1);
        if (residue_a_i == residue_b_i) begin
          match_q <= match_q + COL_W'(1);
        end
      end
      if (last_column_i) begin
        last_pair_q <= last_pair_i;
      end
    end
  end

  // Divider operands
  assign num     = mode_q ? (site_q - match_q) : match_q;
  assign div_dvd = cmd_i.div_avg ? sum_q : SUM_W'({num, {FRAC_W{1'b0}}});
  assign div_dvs = cmd_i.div_avg ? pcnt_q : PAIR_W'(site_q);

  pidc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Pair result and average capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.pair_begin) begin
      dist_q <= '0;
      avg_q  <= '0;
      none_q <= (site_q == '0);
    end else begin
      if (cmd_i.dist_take) dist_q <= div_quo;
      if (cmd_i.avg_take)  avg_q  <= div_quo;
    end
  end

  // Set statistics: update on each pair with sites, clear when the set is reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= Q_W'(ONE_Q16);
      max_q  <= '0;
      sum_q  <= '0;
      pcnt_q <= '0;
    end else if (cmd_i.out_load && last_pair_q) begin
      min_q  <= Q_W'(ONE_Q16);
      max_q  <= '0;
      sum_q  <= '0;
      pcnt_q <= '0;
    end else if (cmd_i.stat_upd && !none_q && (pcnt_q < PAIR_W'(MAX_PAIRS))) begin
      if (dist_q < min_q) min_q <= dist_q;
      if (dist_q > max_q) max_q <= dist_q;
      sum_q  <= sum_q + SUM_W'(dist_q);
      pcnt_q <= pcnt_q + PAIR_W'(1);
    end
  end

  assign set_empty = (pcnt_q == '0);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_last_q <= last_pair_q;
      out_user_q <= {last_pair_q && set_empty, none_q};
      if (last_pair_q) begin
        out_data_q <= OUT_DW'({avg_q, max_q, min_q, dist_q});
      end else begin
        out_data_q <= OUT_DW'(dist_q);
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;
  assign m_tlast_o  = out_last_q;

  // Status back to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.sites_zero = (site_q == '0);
    sts_o.last_pair  = last_pair_q;
    sts_o.pairs_zero = set_empty;
    sts_o.div_busy   = div_busy;
    sts_o.div_done   = div_done;
    sts_o.out_free   = !out_valid_q || m_tready_i;
  end

endmodule

// ===== sv/pidc_ctrl.sv =====
// Controller of the pairwise distance core: sequences counting, divides, statistics, output.
// Depends on pidc_pkg; commands pidc_dp through pidc_cmd_t.
module pidc_ctrl import pidc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  output logic      in_ready_o,
  input  pidc_sts_t sts_i,
  output pidc_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;  // taking column beats
  localparam logic [2:0] S_PAIR = 3'd1;  // pair closed, launch distance divide
  localparam logic [2:0] S_DIVD = 3'd2;  // distance divide running
  localparam logic [2:0] S_STAT = 3'd3;  // fold into set statistics
  localparam logic [2:0] S_AVGS = 3'd4;  // launch average divide
  localparam logic [2:0] S_DIVA = 3'd5;  // average divide running
  localparam logic [2:0] S_OUT  = 3'd6;  // wait for output register

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.col_acc = in_valid_i;
        if (in_valid_i && in_last_i) state_d = S_PAIR;
      end
      S_PAIR: begin
        cmd_o.pair_begin = 1'b1;
        if (sts_i.sites_zero) begin
          state_d = S_STAT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVD;
        end
      end
      S_DIVD: begin
        if (sts_i.div_done) begin
          cmd_o.dist_take = 1'b1;
          state_d         = S_STAT;
        end
      end
      S_STAT: begin
        cmd_o.stat_upd = 1'b1;
        state_d        = sts_i.last_pair ? S_AVGS : S_OUT;
      end
      S_AVGS: begin
        if (sts_i.pairs_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_avg   = 1'b1;
          state_d         = S_DIVA;
        end
      end
      S_DIVA: begin
        cmd_o.div_avg = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.avg_take = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/pairwise_identity_distance_core.sv =====
// Pairwise identity / p-distance core with per-set min, max and mean.
// Input beat: one alignment column; tdata = {residue_b, residue_a}, tlast = last column
// of the pair, tuser = last pair of the set (read with tlast only).
// Output beat: one per pair; tdata = {avg, max, min, distance} in Q1.16 (17 bits each,
// zero padded to 72), tlast = set done, tuser = {no_pairs, no_sites}. The set fields
// are zero unless tlast is high.
// distance_mode (cfg_wdata_i, reset 1) picks p-distance (1) or identity (0); write it
// only while the core is idle.
// Input flow: a column beat that does not close a pair finds the input ready. A closing beat
// holds the input off until its result is loaded into the output register; meanwhile the
// shared 17-step bit-serial divider runs for the distance and, when the beat also closes a
// set with included pairs, for the average. A pair without sites skips the distance divide.
// A set without included pairs skips the average divide.
// The output register holds one finished result; if the receiver stalls, the next pair
// is still counted and the core waits with its result until the register frees up.
// Reset clears the counters and statistics and sets distance_mode to p-distance.
module pairwise_identity_distance_core import pidc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,   // [7:0] residue_a, [15:8] residue_b
  input  logic              s_axis_tlast,   // last_column
  input  logic              s_axis_tuser,   // last_pair
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // [16:0] distance, [33:17] min_distance,
                                            // [50:34] max_distance, [67:51] avg_distance
  output logic [OUT_UW-1:0] m_axis_tuser,   // [0] no_sites, [1] no_pairs
  output logic              m_axis_tlast    // set_done
);

  `include "pairwise_identity_distance_core_assert.svh"

  pidc_cmd_t cmd;
  pidc_sts_t sts;

  pidc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pidc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .residue_a_i   (s_axis_tdata[RES_W-1:0]),
    .residue_b_i   (s_axis_tdata[IN_DW-1:RES_W]),
    .last_column_i (s_axis_tlast),
    .last_pair_i   (s_axis_tuser),
    .m_tready_i    (m_axis_tready),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tdata_o     (m_axis_tdata),
    .m_tuser_o     (m_axis_tuser),
    .m_tlast_o     (m_axis_tlast)
  );

  // Checks
  `PIDC_ASSERT(a_no_accept_while_div, sts.div_busy |-> !s_axis_tready, "beat taken during divide")
  `PIDC_ASSERT(a_load_shows_valid, cmd.out_load |=> m_axis_tvalid, "loaded result not valid")
  `PIDC_ASSERT(a_dist_range, m_axis_tvalid |-> (m_axis_tdata[Q_W-1:0] <= Q_W'(ONE_Q16)),
    "distance above one")
  `PIDC_ASSERT(a_set_fields_gated,
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[4*Q_W-1:Q_W] == '0),
    "set fields nonzero outside set close")

endmodule
